// File: rtl/core/ajb_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the audio jitter buffer dac feed
// no dependencies

package ajb_pkg;

  localparam int DEPTH = 4096;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int PRIME_W = 13;
  localparam int CMP_W = (CNT_W > PRIME_W) ? CNT_W : PRIME_W;

  localparam logic [1:0] OP_PUSH    = 2'd0;
  localparam logic [1:0] OP_TICK    = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  localparam logic [1:0] REG_GAIN    = 2'd0;
  localparam logic [1:0] REG_CHANNEL = 2'd1;
  localparam logic [1:0] REG_PRIME   = 2'd2;

  localparam logic [15:0] GAIN_RESET = 16'd16384;
  localparam logic [PRIME_W-1:0] PRIME_RESET = 13'd480;

  localparam logic [11:0] MIDSCALE = 12'd2048;
  localparam logic [15:0] WORD_ACTIVE = 16'h3000;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [15:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [15:0] dac_word;
    logic        priming;
  } out_item_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic restart;
    logic prime;
  } ring_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] fill;
    logic             primed;
  } ring_stat_t;

  typedef struct packed {
    logic mul_en;
    logic scl_en;
  } conv_ctl_t;

  function automatic logic [15:0] pack_word(input logic chan, input logic [11:0] level);
    pack_word = {chan, 15'd0} | WORD_ACTIVE | {4'd0, level};
  endfunction

endpackage

// File: rtl/core/ajb_ring.sv
`timescale 1ns / 1ps
// sample ring: storage memory, pointers, fill count and primed flag
// depends on ajb_pkg

module ajb_ring (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ajb_pkg::ring_cmd_t    cmd,
  input  logic [15:0]           wr_sample,
  output ajb_pkg::ring_stat_t   stat,
  output logic [15:0]           rd_data
);

  logic [15:0] mem [ajb_pkg::DEPTH];
  logic [ajb_pkg::PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [ajb_pkg::CNT_W-1:0] fill_r;
  logic                      primed_r;
  logic [15:0]               rd_data_r;
  logic                      full;
  logic                      do_push;
  logic                      do_pop;

  assign full    = (fill_r == ajb_pkg::CNT_W'(ajb_pkg::DEPTH));
  assign do_push = cmd.push && !full;
  assign do_pop  = cmd.pop && (fill_r != '0);

  function automatic logic [ajb_pkg::PTR_W-1:0] ptr_inc(input logic [ajb_pkg::PTR_W-1:0] p);
    ptr_inc = (p == ajb_pkg::PTR_W'(ajb_pkg::DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wr_sample;
    end
    if (do_pop) begin
      rd_data_r <= mem[rd_ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
      primed_r <= 1'b0;
    end else if (cmd.restart) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
      primed_r <= 1'b0;
    end else begin
      if (cmd.prime) begin
        primed_r <= 1'b1;
      end
      if (do_push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
        fill_r   <= fill_r + 1'b1;
      end else if (do_pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
        fill_r   <= fill_r - 1'b1;
      end
    end
  end

  assign stat.fill   = fill_r;
  assign stat.primed = primed_r;
  assign rd_data     = rd_data_r;

endmodule

// File: rtl/core/ajb_conv.sv
`timescale 1ns / 1ps
// sample to 12-bit dac level: gain multiply, clamp, scale and round
// depends on ajb_pkg

module ajb_conv (
  input  logic                clk,
  input  ajb_pkg::conv_ctl_t  ctl,
  input  logic signed [15:0]  sample,
  input  logic [15:0]         gain,
  output logic [11:0]         level
);

  localparam logic signed [32:0] CLAMP_HI = 33'sd1072668082;
  localparam logic signed [32:0] CLAMP_LO = -33'sd1072668082;
  localparam logic signed [32:0] HALF_P   = 33'sd1073741824;
  localparam logic [43:0]        HALF_S   = 44'd1073741824;
  localparam logic [11:0]        SCALE    = 12'd4095;

  logic signed [32:0] prod_r;
  logic [42:0]        scl_r;
  logic signed [32:0] prod_nxt;
  logic signed [32:0] clamped;
  logic signed [32:0] biased;
  logic [30:0]        num;
  logic [42:0]        scl_nxt;
  logic [43:0]        rounded;
  logic [12:0]        lvl_raw;

  assign prod_nxt = sample * $signed({1'b0, gain});

  always_comb begin
    if (prod_r > CLAMP_HI) begin
      clamped = CLAMP_HI;
    end else if (prod_r < CLAMP_LO) begin
      clamped = CLAMP_LO;
    end else begin
      clamped = prod_r;
    end
  end

  assign biased  = clamped + HALF_P;
  assign num     = biased[30:0];
  assign scl_nxt = {12'd0, num} * {31'd0, SCALE};

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= prod_nxt;
    end
    if (ctl.scl_en) begin
      scl_r <= scl_nxt;
    end
  end

  assign rounded = {1'b0, scl_r} + HALF_S;
  assign lvl_raw = rounded[43:31];
  assign level   = (lvl_raw > 13'd4095) ? 12'd4095 : lvl_raw[11:0];

endmodule

// File: rtl/core/audio_jitter_buffer_dac_feed.sv
`timescale 1ns / 1ps
// Jitter buffer for signed 16-bit audio feeding 16-bit dac command words. A push
// request stores a sample in a 4096-entry ring (dropped when full); a restart
// request clears the ring and the primed state. A tick request while priming is
// accepted and then loads the midscale filler word into the output register. A
// tick that plays a sample goes through the synchronous ring read, the gain
// multiply, the scale multiply and the load of the output register. A tick that
// finds the ring empty outside priming gives no word. Only one request is in work
// at a time, but a finished word waits in its own output register, so pushes keep
// flowing while the output side stalls; a second word stalls the input until the
// first is taken. No clearing pass follows reset.
// Depends on ajb_pkg, ajb_ring and ajb_conv.

module audio_jitter_buffer_dac_feed (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ajb_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ajb_pkg::out_item_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_SCL  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [15:0]                    gain_r;
  logic                           chan_r;
  logic [ajb_pkg::PRIME_W-1:0]    prime_r;
  logic                           mid_r, mid_nxt;
  logic                           out_valid_r;
  ajb_pkg::out_item_t             out_data_r;

  ajb_pkg::ring_cmd_t  ring_cmd;
  ajb_pkg::ring_stat_t ring_stat;
  ajb_pkg::conv_ctl_t  conv_ctl;
  logic [15:0]         rd_data;
  logic [11:0]         level;
  logic                in_acc;
  logic                is_tick;
  logic                below_prime;
  logic                out_free;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign is_tick   = in_acc && (in_data.operation == ajb_pkg::OP_TICK);
  assign out_free  = !out_valid_r || out_ready;
  assign below_prime = ajb_pkg::CMP_W'(ring_stat.fill) < ajb_pkg::CMP_W'(prime_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r  <= ajb_pkg::GAIN_RESET;
      chan_r  <= 1'b0;
      prime_r <= ajb_pkg::PRIME_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ajb_pkg::REG_GAIN:    gain_r  <= cfg_data;
        ajb_pkg::REG_CHANNEL: chan_r  <= cfg_data[0];
        ajb_pkg::REG_PRIME:   prime_r <= cfg_data[ajb_pkg::PRIME_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ring_cmd.push    = in_acc && (in_data.operation == ajb_pkg::OP_PUSH);
    ring_cmd.restart = in_acc && (in_data.operation == ajb_pkg::OP_RESTART);
    ring_cmd.prime   = is_tick && !ring_stat.primed && !below_prime;
    ring_cmd.pop     = is_tick && (ring_stat.primed || !below_prime)
                       && (ring_stat.fill != '0);
    conv_ctl.mul_en  = (state_r == ST_MUL);
    conv_ctl.scl_en  = (state_r == ST_SCL);
  end

  always_comb begin
    state_nxt = state_r;
    mid_nxt   = mid_r;
    case (state_r)
      ST_IDLE: begin
        if (is_tick && !ring_stat.primed && below_prime) begin
          mid_nxt   = 1'b1;
          state_nxt = ST_OUT;
        end else if (ring_cmd.pop) begin
          mid_nxt   = 1'b0;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: state_nxt = ST_SCL;
      ST_SCL: state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mid_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mid_r   <= mid_nxt;
      if (state_r == ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_OUT && out_free) begin
      out_data_r.dac_word <= ajb_pkg::pack_word(chan_r, mid_r ? ajb_pkg::MIDSCALE : level);
      out_data_r.priming  <= mid_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  ajb_ring u_ring (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (ring_cmd),
    .wr_sample (in_data.sample),
    .stat      (ring_stat),
    .rd_data   (rd_data)
  );

  ajb_conv u_conv (
    .clk    (clk),
    .ctl    (conv_ctl),
    .sample (rd_data),
    .gain   (gain_r),
    .level  (level)
  );

endmodule
